### rtl/mspt_pkg.sv
// Shared types, codes and sizes for the periodic timer table.
package mspt_pkg;

    // Table geometry
    localparam int NUM_SLOTS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
    localparam int REP_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int OP_W   = 3;
    localparam int ID_W   = 4;
    localparam int TIME_W = 16;
    localparam int STAT_W = 2;

    // Configuration space
    localparam int          ADDR_W           = 3;
    localparam logic [ADDR_W-1:0] ADDR_MAX_INTERVAL = 3'd0;
    localparam logic [TIME_W-1:0] MAX_INTERVAL_RST  = 16'hFFFF;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_PAUSE  = 3'd2,
        OP_RESUME = 3'd3,
        OP_DELETE = 3'd4,
        OP_GET    = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_INTERVAL = 2'd1,
        ST_NO_SLOT     = 2'd2,
        ST_BAD_ID      = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;   // take the input beat
        logic exec;    // run a non-tick operation and post its result
        logic step;    // advance the scan by one slot
        logic flush;   // post the final tick result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_tick;   // incoming beat is a tick
        logic step_ok;   // current slot can be processed this cycle
        logic scan_last; // scan sits on the highest slot
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

### rtl/multi_slot_periodic_timer_unit.sv
// Top level of the periodic timer table: register port, controller and datapath.
//
// A table of eight periodic timers driven by one operation beat at a time.
// A tick visits the slots one per cycle through a single increment-and-compare
// unit (accept, one step per slot, then the post of the final result); each
// expiry is posted while the scan continues, and the scan waits only when the
// output beat ahead is still stalled. Create, pause, resume, delete and get-state
// are accepted, then executed as soon as the output register is free. The next
// operation is taken while the last result still waits in the output register.
// max_interval is written at byte address 0 and must only be changed while idle.
module multi_slot_periodic_timer_unit import mspt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // operation channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ID_W-1:0]   i_slot_id,
    input  logic [TIME_W-1:0] i_interval,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_value,
    output logic              o_fired,
    output logic [ID_W-1:0]   o_fired_id,
    output logic              o_last,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [TIME_W-1:0] r_max_interval;
    t_cmd              cmd;
    t_stat             stat;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_INTERVAL) ? 32'(r_max_interval) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_interval <= MAX_INTERVAL_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_MAX_INTERVAL)) begin
            r_max_interval <= pwdata[TIME_W-1:0];
        end
    end

    mspt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mspt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_max_interval (r_max_interval),
        .i_op           (i_op),
        .i_slot_id      (i_slot_id),
        .i_interval     (i_interval),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_value        (o_value),
        .o_fired        (o_fired),
        .o_fired_id     (o_fired_id),
        .o_last         (o_last)
    );

    // An accepted beat keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after an accept");

    // An expiry beat carries a slot id and nothing else
    a_fired_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fired) |->
            (o_status == ST_OK) && (o_value == '0) && (o_fired_id != '0))
        else $error("malformed expiry beat");

    // A beat without an expiry has no id and is marked last
    a_no_fire_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_fired) |-> (o_fired_id == '0) && o_last)
        else $error("non-expiry beat with id or without last");

endmodule

### rtl/mspt_ctrl.sv
// Sequencing state machine for the periodic timer table.
module mspt_ctrl import mspt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_tick ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.step_ok && i_stat.scan_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.latch = i_in_valid;
            end
            S_EXEC:  o_cmd.exec  = i_stat.out_free;
            S_SCAN:  o_cmd.step  = i_stat.step_ok;
            S_FLUSH: o_cmd.flush = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/mspt_dp.sv
// Slot table, scan logic and output register of the periodic timer table.
module mspt_dp import mspt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [TIME_W-1:0] i_max_interval,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ID_W-1:0]   i_slot_id,
    input  logic [TIME_W-1:0] i_interval,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [ID_W-1:0]   o_value,
    output logic              o_fired,
    output logic [ID_W-1:0]   o_fired_id,
    output logic              o_last
);

    // Latched operation
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_interval;

    // Slot table
    logic [NUM_SLOTS-1:0] r_used;
    logic [NUM_SLOTS-1:0] r_active;
    logic [TIME_W-1:0]    r_period  [NUM_SLOTS];
    logic [TIME_W-1:0]    r_elapsed [NUM_SLOTS];
    logic [CNT_W-1:0]     r_used_cnt;

    // Scan state
    logic [IDX_W-1:0] r_idx;
    logic [REP_W-1:0] r_nrep;
    logic             r_pend_valid;
    logic [ID_W-1:0]  r_pend_id;

    // Output register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [ID_W-1:0]   r_value;
    logic              r_fired;
    logic [ID_W-1:0]   r_fired_id;
    logic              r_last;

    logic              out_free;
    logic              tick_en;
    logic [TIME_W-1:0] elapsed_inc;
    logic              expire;
    logic              report;
    logic [ID_W-1:0]   scan_id;

    logic [6:0]        id_ext;
    logic              id_ok;
    logic [IDX_W-1:0]  sel;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              intv_bad;
    logic              table_full;

    // Exec result
    logic [STAT_W-1:0] ex_status;
    logic [ID_W-1:0]   ex_value;

    assign out_free = !r_out_valid || !i_out_stall;

    // Scan of one slot through the shared increment and compare
    assign tick_en     = r_used[r_idx] && r_active[r_idx];
    assign elapsed_inc = r_elapsed[r_idx] + 1'b1;
    assign expire      = tick_en && (elapsed_inc >= r_period[r_idx]);
    assign report      = expire && (r_nrep < REP_W'(MAX_RESULTS));
    assign scan_id     = ID_W'(7'(r_idx) + 7'd1);

    assign o_stat.in_tick   = (i_op == OP_TICK);
    assign o_stat.step_ok   = !(report && r_pend_valid) || out_free;
    assign o_stat.scan_last = (r_idx == IDX_W'(NUM_SLOTS - 1));
    assign o_stat.out_free  = out_free;

    // Id decode for the per-slot operations
    assign id_ext = 7'(r_id) - 7'd1;
    assign id_ok  = (r_id != '0) && (7'(r_id) <= 7'(NUM_SLOTS));
    assign sel    = id_ext[IDX_W-1:0];

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign intv_bad   = (r_interval == '0) || (r_interval > i_max_interval);
    assign table_full = (r_used_cnt >= CNT_W'(NUM_SLOTS)) || !free_found;

    // Result of a non-tick operation
    always_comb begin
        ex_status = ST_OK;
        ex_value  = '0;
        unique case (r_op)
            OP_CREATE: begin
                if (intv_bad) begin
                    ex_status = ST_BAD_INTERVAL;
                end else if (table_full) begin
                    ex_status = ST_NO_SLOT;
                end else begin
                    ex_value = ID_W'(7'(free_idx) + 7'd1);
                end
            end
            OP_PAUSE, OP_RESUME, OP_DELETE: begin
                if (!id_ok) begin
                    ex_status = ST_BAD_ID;
                end
            end
            OP_GET: begin
                if (!id_ok) begin
                    ex_status = ST_BAD_ID;
                end else begin
                    ex_value = ID_W'(r_active[sel]);
                end
            end
            default: begin
                ex_status = ST_OK;
                ex_value  = '0;
            end
        endcase
    end

    // Input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= i_op;
            r_id       <= i_slot_id;
            r_interval <= i_interval;
        end
    end

    // Slot flags and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_active   <= '0;
            r_used_cnt <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_CREATE: begin
                    if (!intv_bad && !table_full) begin
                        r_used[free_idx]   <= 1'b1;
                        r_active[free_idx] <= 1'b1;
                        r_used_cnt         <= r_used_cnt + 1'b1;
                    end
                end
                OP_PAUSE: begin
                    if (id_ok) r_active[sel] <= 1'b0;
                end
                OP_RESUME: begin
                    if (id_ok) r_active[sel] <= 1'b1;
                end
                OP_DELETE: begin
                    if (id_ok) begin
                        if (r_used[sel] && (r_used_cnt != '0)) begin
                            r_used_cnt <= r_used_cnt - 1'b1;
                        end
                        r_used[sel]   <= 1'b0;
                        r_active[sel] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Period and elapsed storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            if (tick_en) begin
                r_elapsed[r_idx] <= expire ? '0 : elapsed_inc;
            end
        end else if (i_cmd.exec) begin
            unique case (r_op)
                OP_CREATE: begin
                    if (!intv_bad && !table_full) begin
                        r_period[free_idx]  <= r_interval;
                        r_elapsed[free_idx] <= '0;
                    end
                end
                OP_RESUME: begin
                    if (id_ok) r_elapsed[sel] <= '0;
                end
                OP_DELETE: begin
                    if (id_ok) begin
                        r_period[sel]  <= '0;
                        r_elapsed[sel] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Scan index, report count and held expiry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_nrep       <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.latch) begin
            r_idx        <= '0;
            r_nrep       <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
            if (report) begin
                r_nrep       <= r_nrep + 1'b1;
                r_pend_valid <= 1'b1;
                r_pend_id    <= scan_id;
            end
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    // Output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
            r_status    <= ex_status;
            r_value     <= ex_value;
            r_fired     <= 1'b0;
            r_fired_id  <= '0;
            r_last      <= 1'b1;
        end else if (i_cmd.step && report && r_pend_valid) begin
            // a newer expiry shows the held one is not the final beat
            r_out_valid <= 1'b1;
            r_status    <= ST_OK;
            r_value     <= '0;
            r_fired     <= 1'b1;
            r_fired_id  <= r_pend_id;
            r_last      <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out_valid <= 1'b1;
            r_status    <= ST_OK;
            r_value     <= '0;
            r_fired     <= r_pend_valid;
            r_fired_id  <= r_pend_valid ? r_pend_id : '0;
            r_last      <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_fired     = r_fired;
    assign o_fired_id  = r_fired_id;
    assign o_last      = r_last;

endmodule

### tb/tb_multi_slot_periodic_timer_unit.sv
// Self-checking testbench for the periodic timer table: operation driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb_multi_slot_periodic_timer_unit import mspt_pkg::*;;

    // op codes outside the defined set; the block answers them with an empty result
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = NUM_SLOTS + 4;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   slot_id;
        logic [TIME_W-1:0] interval;
    } t_timer_cmd;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   value;
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic              last;
    } t_timer_result;

    // DUT connections
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_op = '0;
    logic [ID_W-1:0]   i_slot_id = '0;
    logic [TIME_W-1:0] i_interval = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [ID_W-1:0]   o_value;
    logic              o_fired;
    logic [ID_W-1:0]   o_fired_id;
    logic              o_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    multi_slot_periodic_timer_unit u_top (.*);

    // Shadow copy of the timer table
    logic              tmr_live   [NUM_SLOTS];
    logic              tmr_run    [NUM_SLOTS];
    logic [TIME_W-1:0] tmr_period [NUM_SLOTS];
    logic [TIME_W-1:0] tmr_age    [NUM_SLOTS];
    int                tmr_live_cnt;
    logic [TIME_W-1:0] limit_shadow;

    t_timer_cmd    op_queue[$];
    t_timer_result expected_results[$];

    int  fail_count = 0;
    int  result_idx = 0;
    bit  in_beat_done = 1'b0;
    int  send_gap = 0;
    int  stall_run = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tmr_live[i]   = 1'b0;
            tmr_run[i]    = 1'b0;
            tmr_period[i] = '0;
            tmr_age[i]    = '0;
        end
        tmr_live_cnt = 0;
        limit_shadow = MAX_INTERVAL_RST;
    end

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endtask

    function automatic void push_result(input logic [STAT_W-1:0] st, input logic [ID_W-1:0] val,
                                        input logic fired, input logic [ID_W-1:0] fid,
                                        input logic last);
        t_timer_result r;
        r.status   = st;
        r.value    = val;
        r.fired    = fired;
        r.fired_id = fid;
        r.last     = last;
        expected_results.push_back(r);
    endfunction

    // Apply one operation to the shadow table and queue the results it produces
    function automatic void predict_timer_op(input t_timer_cmd c);
        logic [ID_W-1:0] expired [$];
        int   s;
        bit   id_ok;
        bit   placed;
        id_ok = (c.slot_id >= 1) && (c.slot_id <= NUM_SLOTS);
        s = id_ok ? int'(c.slot_id) - 1 : 0;
        placed = 1'b0;
        case (c.op)
            OP_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tmr_live[i] && tmr_run[i]) begin
                        tmr_age[i] = tmr_age[i] + 1'b1;
                        if (tmr_age[i] >= tmr_period[i]) begin
                            tmr_age[i] = '0;
                            if (expired.size() < MAX_RESULTS) expired.push_back(ID_W'(i + 1));
                        end
                    end
                end
                if (expired.size() == 0) push_result(ST_OK, '0, 1'b0, '0, 1'b1);
                for (int k = 0; k < expired.size(); k++)
                    push_result(ST_OK, '0, 1'b1, expired[k], k == expired.size() - 1);
            end
            OP_CREATE: begin
                if (c.interval == '0 || c.interval > limit_shadow) begin
                    push_result(ST_BAD_INTERVAL, '0, 1'b0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!placed && !tmr_live[i] && tmr_live_cnt < NUM_SLOTS) begin
                            placed        = 1'b1;
                            tmr_live[i]   = 1'b1;
                            tmr_run[i]    = 1'b1;
                            tmr_period[i] = c.interval;
                            tmr_age[i]    = '0;
                            tmr_live_cnt++;
                            push_result(ST_OK, ID_W'(i + 1), 1'b0, '0, 1'b1);
                        end
                    end
                    if (!placed) push_result(ST_NO_SLOT, '0, 1'b0, '0, 1'b1);
                end
            end
            OP_PAUSE, OP_RESUME, OP_DELETE, OP_GET: begin
                if (!id_ok) begin
                    push_result(ST_BAD_ID, '0, 1'b0, '0, 1'b1);
                end else if (c.op == OP_GET) begin
                    push_result(ST_OK, ID_W'(tmr_run[s]), 1'b0, '0, 1'b1);
                end else begin
                    if (c.op == OP_PAUSE) begin
                        tmr_run[s] = 1'b0;
                    end else if (c.op == OP_RESUME) begin
                        tmr_run[s] = 1'b1;
                        tmr_age[s] = '0;
                    end else begin
                        // delete of a free slot leaves the count alone
                        if (tmr_live[s] && tmr_live_cnt > 0) tmr_live_cnt--;
                        tmr_live[s]   = 1'b0;
                        tmr_run[s]    = 1'b0;
                        tmr_period[s] = '0;
                        tmr_age[s]    = '0;
                    end
                    push_result(ST_OK, '0, 1'b0, '0, 1'b1);
                end
            end
            default: push_result(ST_OK, '0, 1'b0, '0, 1'b1);
        endcase
    endfunction

    // Operation driver: one beat per pending command, with random gaps after a beat
    always @(negedge i_clk) begin
        t_timer_cmd nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat_done) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                nxt = op_queue.pop_front();
                i_in_valid <= 1'b1;
                i_op       <= nxt.op;
                i_slot_id  <= nxt.slot_id;
                i_interval <= nxt.interval;
                if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 11);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_beat_done = 1'b0;
    end

    // Result-side backpressure in bursts
    always @(negedge i_clk) begin
        if (stall_run > 0) begin
            stall_run--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            stall_run = $urandom_range(1, 11) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: check result beats, then feed accepted operation beats to the predictor
    always @(posedge i_clk) begin
        t_timer_result want;
        t_timer_cmd    got_cmd;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing pending", result_idx));
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status || o_value !== want.value || o_fired !== want.fired
                    || o_fired_id !== want.fired_id || o_last !== want.last)
                    report_mismatch({
                        $sformatf("result %0d exp st=%0d val=%0d fired=%0d id=%0d last=%0d",
                                  result_idx, want.status, want.value, want.fired,
                                  want.fired_id, want.last),
                        $sformatf(" got st=%0d val=%0d fired=%0d id=%0d last=%0d",
                                  o_status, o_value, o_fired, o_fired_id, o_last)});
            end
            result_idx++;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            got_cmd.op       = i_op;
            got_cmd.slot_id  = i_slot_id;
            got_cmd.interval = i_interval;
            predict_timer_op(got_cmd);
            in_beat_done = 1'b1;
        end
    end

    task automatic queue_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [TIME_W-1:0] ivl);
        t_timer_cmd c;
        c.op       = op;
        c.slot_id  = id;
        c.interval = ivl;
        op_queue.push_back(c);
    endtask

    // Mostly valid ids and short periods so timers expire often
    task automatic queue_random(input int count, input logic [TIME_W-1:0] lim);
        t_timer_cmd c;
        int pick;
        int top;
        top = (lim < 8) ? int'(lim) + 1 : 8;
        for (int n = 0; n < count; n++) begin
            c.interval = TIME_W'($urandom);
            if ($urandom_range(0, 99) < 85) c.slot_id = ID_W'($urandom_range(1, NUM_SLOTS));
            else c.slot_id = ID_W'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 40)      c.op = OP_TICK;
            else if (pick < 60) c.op = OP_CREATE;
            else if (pick < 68) c.op = OP_PAUSE;
            else if (pick < 76) c.op = OP_RESUME;
            else if (pick < 88) c.op = OP_DELETE;
            else if (pick < 98) c.op = OP_GET;
            else                c.op = (pick % 2) ? OP_SPARE_A : OP_SPARE_B;
            if (c.op == OP_CREATE) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      c.interval = TIME_W'($urandom_range(1, top));
                else if (pick < 78) c.interval = '0;
                else if (pick < 88) c.interval = lim;
                else if (pick < 94) c.interval = lim + 1'b1;
            end
            op_queue.push_back(c);
        end
    endtask

    // Sender holds back until every beat is in and every result is out
    task automatic wait_drained;
        while (op_queue.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_read_check(input logic [TIME_W-1:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_INTERVAL;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[TIME_W-1:0] !== want)
            report_mismatch($sformatf("max_interval read exp %0d got %0d", want,
                                      prdata[TIME_W-1:0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_write(input logic [TIME_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_INTERVAL;
        pwdata  <= {16'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_shadow = val;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_read_check(val);
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] lim, input int send_pct, input int recv_pct,
                             input int count);
        cfg_write(lim);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random(count, lim);
        wait_drained;
    endtask

    // Stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        cfg_read_check(MAX_INTERVAL_RST);

        // directed: corner cases with the reset limit
        send_idle_pct = 30;
        recv_idle_pct = 10;
        queue_op(OP_TICK, 4'd0, 16'd0);          // empty table
        queue_op(OP_CREATE, 4'd1, 16'd0);        // zero period
        queue_op(OP_CREATE, 4'd0, 16'hFFFF);     // largest period, slot 1
        queue_op(OP_CREATE, 4'd15, 16'd1);       // slot 2
        queue_op(OP_CREATE, 4'd0, 16'd2);        // slot 3
        queue_op(OP_GET, 4'd1, 16'hA5A5);
        queue_op(OP_TICK, 4'd15, 16'hFFFF);
        queue_op(OP_TICK, 4'd0, 16'd0);          // slots 2 and 3 together
        queue_op(OP_PAUSE, 4'd2, 16'd0);
        queue_op(OP_GET, 4'd2, 16'd0);
        queue_op(OP_TICK, 4'd0, 16'd0);          // nothing due
        queue_op(OP_RESUME, 4'd2, 16'd0);
        queue_op(OP_DELETE, 4'd1, 16'd0);
        queue_op(OP_DELETE, 4'd1, 16'd0);        // already free
        queue_op(OP_PAUSE, 4'd0, 16'd0);         // bad ids
        queue_op(OP_RESUME, 4'd9, 16'd0);
        queue_op(OP_GET, 4'd15, 16'd0);
        queue_op(OP_SPARE_A, 4'd5, 16'h1234);
        queue_op(OP_SPARE_B, 4'd15, 16'hFFFF);
        queue_op(OP_RESUME, 4'd8, 16'd0);        // free slot keeps its active bit
        queue_op(OP_GET, 4'd8, 16'd0);
        queue_op(OP_PAUSE, 4'd8, 16'd0);
        for (int i = 0; i < 6; i++) queue_op(OP_CREATE, 4'd0, 16'd1);
        queue_op(OP_CREATE, 4'd0, 16'd3);        // table full
        queue_op(OP_CREATE, 4'd0, 16'd0);        // period checked before capacity
        queue_op(OP_TICK, 4'd0, 16'd0);          // all eight expire
        wait_drained;

        // random phases over several limits, the extremes among them
        run_phase(16'd1, 40, 15, 20);
        run_phase(16'hFFFF, 10, 25, 30);
        run_phase(TIME_W'($urandom_range(2, 20)), 50, 5, 30);

        // closing stretch without idling
        send_gap  = 0;
        stall_run = 0;
        run_phase(16'd7, 0, 0, 20);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
